/* rtl/core/mer_pkg.sv */
// Shared types, microcode encoding and control store of the midpoint ellipse rasterizer.
package mer_pkg;

    // Field widths
    localparam int COORD_W  = 12;
    localparam int RADIUS_W = 10;
    localparam int OUT_W    = 14;
    localparam int STEP_W   = 11;
    localparam int SQ_W     = 20;
    localparam int TERM_W   = 33;
    localparam int DEC_W    = 44;
    localparam int ACC_W    = 46;
    localparam int TMP_W    = 24;
    localparam int MUL_A_W  = 21;
    localparam int MUL_B_W  = 25;

    // Microcode address space
    localparam int UA_W     = 5;
    localparam int UA_DEPTH = 1 << UA_W;

    typedef logic [UA_W-1:0] uaddr_t;

    typedef enum logic [0:0] {
        OP_START = 1'b0,
        OP_STEP  = 1'b1
    } op_t;

    // Multiplier operand pairs
    typedef enum logic [3:0] {
        MUL_NONE,
        MUL_RX_RX,
        MUL_RY_RY,
        MUL_RX2_RY,
        MUL_TX_TX,
        MUL_YM_YM,
        MUL_RY2_TMP,
        MUL_RX2_TMP,
        MUL_RX2_RY2
    } mul_op_t;

    // Accumulator updates
    typedef enum logic [3:0] {
        ACC_HOLD,
        ACC_INIT,
        ACC_PLUS_RX2,
        ACC_DEC_PLUS_RY2,
        ACC_DEC_PLUS_RX2,
        ACC_PLUS_XT,
        ACC_MINUS_YT,
        ACC_FROM_PROD,
        ACC_PLUS_4PROD,
        ACC_MINUS_4PROD
    } acc_op_t;

    // Coordinate steps
    typedef enum logic [1:0] {
        STP_NONE,
        STP_X,
        STP_Y
    } step_op_t;

    // Register writes
    typedef enum logic [3:0] {
        ROP_NONE,
        ROP_RX2_PROD,
        ROP_RY2_PROD,
        ROP_YT_2PROD,
        ROP_TMP_PROD,
        ROP_DEC_TRUNC,
        ROP_DEC_ACC,
        ROP_R2_ENTER,
        ROP_BUSY_UPD
    } reg_op_t;

    typedef enum logic [1:0] {
        JMP_NEVER,
        JMP_ALWAYS,
        JMP_DEC_NEG,
        JMP_DEC_POS
    } jmp_cond_t;

    typedef enum logic [1:0] {
        FIN_NEVER,
        FIN_ALWAYS,
        FIN_XT_LT_YT
    } fin_cond_t;

    typedef struct packed {
        mul_op_t   mul;
        acc_op_t   acc;
        step_op_t  stp;
        reg_op_t   rop;
        jmp_cond_t jmp;
        fin_cond_t fin;
        uaddr_t    target;
    } uword_t;

    // Sequencer to datapath
    typedef struct packed {
        logic   exec;
        uword_t w;
    } ctrl_t;

    // Datapath to sequencer
    typedef struct packed {
        logic busy;
        logic r2;
        logic dec_neg;
        logic dec_pos;
        logic xt_lt_yt;
    } status_t;

    // One result transaction
    typedef struct packed {
        logic [OUT_W-1:0] left_top_y;
        logic [OUT_W-1:0] left_top_x;
        logic [OUT_W-1:0] right_top_y;
        logic [OUT_W-1:0] right_top_x;
        logic [OUT_W-1:0] left_bottom_y;
        logic [OUT_W-1:0] left_bottom_x;
        logic [OUT_W-1:0] right_bottom_y;
        logic [OUT_W-1:0] right_bottom_x;
        logic             last;
    } result_t;

    // Program entry points and jump targets
    localparam uaddr_t UA_START   = 5'd0;
    localparam uaddr_t UA_R1      = 5'd6;
    localparam uaddr_t UA_R1_JOIN = 5'd10;
    localparam uaddr_t UA_R2E     = 5'd11;
    localparam uaddr_t UA_R2      = 5'd18;
    localparam uaddr_t UA_R2_JOIN = 5'd22;

    localparam uword_t UW_PAD =
        '{MUL_NONE, ACC_HOLD, STP_NONE, ROP_NONE, JMP_NEVER, FIN_ALWAYS, UA_START};

    // Control store: one word per microprogram address
    localparam uword_t UCODE [UA_DEPTH] = '{
        // start: squares, y term and region-one decision
        '{MUL_RX_RX,   ACC_HOLD,         STP_NONE, ROP_NONE,      JMP_NEVER,   FIN_NEVER,    UA_START},
        '{MUL_RY_RY,   ACC_HOLD,         STP_NONE, ROP_RX2_PROD,  JMP_NEVER,   FIN_NEVER,    UA_START},
        '{MUL_RX2_RY,  ACC_HOLD,         STP_NONE, ROP_RY2_PROD,  JMP_NEVER,   FIN_NEVER,    UA_START},
        '{MUL_NONE,    ACC_INIT,         STP_NONE, ROP_YT_2PROD,  JMP_NEVER,   FIN_NEVER,    UA_START},
        '{MUL_NONE,    ACC_PLUS_RX2,     STP_NONE, ROP_NONE,      JMP_NEVER,   FIN_NEVER,    UA_START},
        '{MUL_NONE,    ACC_HOLD,         STP_NONE, ROP_DEC_TRUNC, JMP_ALWAYS,  FIN_XT_LT_YT, UA_R2E},
        // region-one iteration
        '{MUL_NONE,    ACC_DEC_PLUS_RY2, STP_X,    ROP_NONE,      JMP_NEVER,   FIN_NEVER,    UA_START},
        '{MUL_NONE,    ACC_PLUS_XT,      STP_NONE, ROP_NONE,      JMP_DEC_NEG, FIN_NEVER,    UA_R1_JOIN},
        '{MUL_NONE,    ACC_HOLD,         STP_Y,    ROP_NONE,      JMP_NEVER,   FIN_NEVER,    UA_START},
        '{MUL_NONE,    ACC_MINUS_YT,     STP_NONE, ROP_NONE,      JMP_NEVER,   FIN_NEVER,    UA_START},
        '{MUL_NONE,    ACC_HOLD,         STP_NONE, ROP_DEC_ACC,   JMP_NEVER,   FIN_XT_LT_YT, UA_START},
        // region-two entry: quarter-unit initial decision
        '{MUL_TX_TX,   ACC_HOLD,         STP_NONE, ROP_NONE,      JMP_NEVER,   FIN_NEVER,    UA_START},
        '{MUL_YM_YM,   ACC_HOLD,         STP_NONE, ROP_TMP_PROD,  JMP_NEVER,   FIN_NEVER,    UA_START},
        '{MUL_RY2_TMP, ACC_HOLD,         STP_NONE, ROP_TMP_PROD,  JMP_NEVER,   FIN_NEVER,    UA_START},
        '{MUL_RX2_TMP, ACC_FROM_PROD,    STP_NONE, ROP_NONE,      JMP_NEVER,   FIN_NEVER,    UA_START},
        '{MUL_RX2_RY2, ACC_PLUS_4PROD,   STP_NONE, ROP_NONE,      JMP_NEVER,   FIN_NEVER,    UA_START},
        '{MUL_NONE,    ACC_MINUS_4PROD,  STP_NONE, ROP_NONE,      JMP_NEVER,   FIN_NEVER,    UA_START},
        '{MUL_NONE,    ACC_HOLD,         STP_NONE, ROP_R2_ENTER,  JMP_NEVER,   FIN_ALWAYS,   UA_START},
        // region-two iteration
        '{MUL_NONE,    ACC_DEC_PLUS_RX2, STP_Y,    ROP_NONE,      JMP_NEVER,   FIN_NEVER,    UA_START},
        '{MUL_NONE,    ACC_MINUS_YT,     STP_NONE, ROP_NONE,      JMP_DEC_POS, FIN_NEVER,    UA_R2_JOIN},
        '{MUL_NONE,    ACC_HOLD,         STP_X,    ROP_NONE,      JMP_NEVER,   FIN_NEVER,    UA_START},
        '{MUL_NONE,    ACC_PLUS_XT,      STP_NONE, ROP_NONE,      JMP_NEVER,   FIN_NEVER,    UA_START},
        '{MUL_NONE,    ACC_HOLD,         STP_NONE, ROP_BUSY_UPD,  JMP_NEVER,   FIN_ALWAYS,   UA_START},
        // unused addresses
        UW_PAD, UW_PAD, UW_PAD, UW_PAD, UW_PAD, UW_PAD, UW_PAD, UW_PAD, UW_PAD
    };

endpackage

/* rtl/core/mer_sequencer.sv */
// Microcode sequencer: step counter, control store read, jumps and dispatch.
module mer_sequencer
    import mer_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    in_fire,
    input  op_t     in_op,
    input  status_t status,
    input  logic    out_block,
    output logic    running,
    output logic    launch,
    output ctrl_t   ctrl,
    output logic    emit
);

    logic   running_reg, running_next;
    logic   is_step_reg, is_step_next;
    uaddr_t pc_reg, pc_next;
    uword_t word;
    logic   jmp_take;
    logic   fin_hit;
    logic   stall;
    logic   exec;
    logic   step_go;

    // Read the current control word
    assign word = UCODE[pc_reg];

    // Evaluate jump and finish conditions
    always_comb begin
        unique case (word.jmp)
            JMP_NEVER:   jmp_take = 1'b0;
            JMP_ALWAYS:  jmp_take = 1'b1;
            JMP_DEC_NEG: jmp_take = status.dec_neg;
            JMP_DEC_POS: jmp_take = status.dec_pos;
        endcase
        unique case (word.fin)
            FIN_NEVER:    fin_hit = 1'b0;
            FIN_ALWAYS:   fin_hit = 1'b1;
            FIN_XT_LT_YT: fin_hit = status.xt_lt_yt;
            default:      fin_hit = 1'b1;
        endcase
    end

    // Hold a step's finishing word while the result register is still occupied
    assign stall   = fin_hit && is_step_reg && out_block;
    assign exec    = running_reg && !stall;
    assign launch  = in_fire && (in_op == OP_START);
    assign step_go = in_fire && (in_op == OP_STEP) && status.busy;

    // Dispatch new transactions and advance the step counter
    always_comb begin
        running_next = running_reg;
        is_step_next = is_step_reg;
        pc_next      = pc_reg;
        priority if (launch) begin
            running_next = 1'b1;
            is_step_next = 1'b0;
            pc_next      = UA_START;
        end else if (step_go) begin
            running_next = 1'b1;
            is_step_next = 1'b1;
            pc_next      = status.r2 ? UA_R2 : UA_R1;
        end else if (exec) begin
            if (fin_hit) begin
                running_next = 1'b0;
            end else if (jmp_take) begin
                pc_next = word.target;
            end else begin
                pc_next = pc_reg + UA_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            running_reg <= 1'b0;
            is_step_reg <= 1'b0;
            pc_reg      <= UA_START;
        end else begin
            running_reg <= running_next;
            is_step_reg <= is_step_next;
            pc_reg      <= pc_next;
        end
    end

    assign running   = running_reg;
    assign ctrl.exec = exec;
    assign ctrl.w    = word;
    assign emit      = exec && fin_hit && is_step_reg;

endmodule

/* rtl/core/mer_datapath.sv */
// Datapath: ellipse state, shared multiplier, accumulator and point generation.
module mer_datapath
    import mer_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                launch,
    input  logic [COORD_W-1:0]  in_center_x,
    input  logic [COORD_W-1:0]  in_center_y,
    input  logic [RADIUS_W-1:0] in_radius_x,
    input  logic [RADIUS_W-1:0] in_radius_y,
    input  ctrl_t               ctrl,
    output status_t             status,
    output result_t             result
);

    logic [COORD_W-1:0]       cx_reg, cx_next;
    logic [COORD_W-1:0]       cy_reg, cy_next;
    logic [RADIUS_W-1:0]      rx_reg, rx_next;
    logic [RADIUS_W-1:0]      ry_reg, ry_next;
    logic [SQ_W-1:0]          rx2_reg, rx2_next;
    logic [SQ_W-1:0]          ry2_reg, ry2_next;
    logic [STEP_W-1:0]        sx_reg, sx_next;
    logic [STEP_W-1:0]        sy_reg, sy_next;
    logic signed [DEC_W-1:0]  dec_reg, dec_next;
    logic signed [TERM_W-1:0] xt_reg, xt_next;
    logic signed [TERM_W-1:0] yt_reg, yt_next;
    logic [TMP_W-1:0]         tmp_reg, tmp_next;
    logic signed [ACC_W-1:0]  prod_reg, prod_next;
    logic signed [ACC_W-1:0]  acc_reg, acc_next;
    logic                     r2_reg, r2_next;
    logic                     busy_reg, busy_next;

    logic [STEP_W:0]          tx;
    logic signed [STEP_W:0]   ym;
    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic signed [ACC_W-1:0]  mul_p;
    logic signed [ACC_W-1:0]  dec_w, xt_w, yt_w, rx2_w, ry2_w, prod4, acc_adj;
    logic [DEC_W-1:0]         dec_trunc;
    logic                     last_busy;
    logic [OUT_W-1:0]         cx14, cy14, sx14, sy14;

    // Select multiplier operands
    assign tx = {sx_reg, 1'b1};
    assign ym = $signed({1'b0, sy_reg}) - (STEP_W+1)'(1);

    always_comb begin
        unique case (ctrl.w.mul)
            MUL_RX_RX: begin
                mul_a = MUL_A_W'(rx_reg);
                mul_b = MUL_B_W'(rx_reg);
            end
            MUL_RY_RY: begin
                mul_a = MUL_A_W'(ry_reg);
                mul_b = MUL_B_W'(ry_reg);
            end
            MUL_RX2_RY: begin
                mul_a = MUL_A_W'(rx2_reg);
                mul_b = MUL_B_W'(ry_reg);
            end
            MUL_TX_TX: begin
                mul_a = MUL_A_W'(tx);
                mul_b = MUL_B_W'(tx);
            end
            MUL_YM_YM: begin
                mul_a = MUL_A_W'(ym);
                mul_b = MUL_B_W'(ym);
            end
            MUL_RY2_TMP: begin
                mul_a = MUL_A_W'(ry2_reg);
                mul_b = MUL_B_W'(tmp_reg);
            end
            MUL_RX2_TMP: begin
                mul_a = MUL_A_W'(rx2_reg);
                mul_b = MUL_B_W'(tmp_reg);
            end
            MUL_RX2_RY2: begin
                mul_a = MUL_A_W'(rx2_reg);
                mul_b = MUL_B_W'(ry2_reg);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    // Widen operands for the accumulator
    assign dec_w = ACC_W'(dec_reg);
    assign xt_w  = ACC_W'(xt_reg);
    assign yt_w  = ACC_W'(yt_reg);
    assign rx2_w = $signed(ACC_W'(rx2_reg));
    assign ry2_w = $signed(ACC_W'(ry2_reg));
    assign prod4 = prod_reg <<< 2;

    // Divide the quarter-unit accumulator by four, truncating towards zero
    assign acc_adj   = acc_reg + (acc_reg[ACC_W-1] ? ACC_W'(3) : ACC_W'(0));
    assign dec_trunc = acc_adj[ACC_W-1:2];

    // Compute next state
    always_comb begin
        cx_next   = cx_reg;
        cy_next   = cy_reg;
        rx_next   = rx_reg;
        ry_next   = ry_reg;
        rx2_next  = rx2_reg;
        ry2_next  = ry2_reg;
        sx_next   = sx_reg;
        sy_next   = sy_reg;
        dec_next  = dec_reg;
        xt_next   = xt_reg;
        yt_next   = yt_reg;
        tmp_next  = tmp_reg;
        prod_next = prod_reg;
        acc_next  = acc_reg;
        r2_next   = r2_reg;
        busy_next = busy_reg;
        priority if (launch) begin
            cx_next   = in_center_x;
            cy_next   = in_center_y;
            rx_next   = in_radius_x;
            ry_next   = in_radius_y;
            sx_next   = '0;
            sy_next   = STEP_W'(in_radius_y);
            xt_next   = '0;
            r2_next   = 1'b0;
            busy_next = 1'b1;
        end else if (ctrl.exec) begin
            if (ctrl.w.mul != MUL_NONE) begin
                prod_next = mul_p;
            end

            unique case (ctrl.w.stp)
                STP_NONE: ;
                STP_X: begin
                    sx_next = sx_reg + STEP_W'(1);
                    xt_next = xt_reg + $signed(TERM_W'({ry2_reg, 1'b0}));
                end
                STP_Y: begin
                    sy_next = sy_reg - STEP_W'(1);
                    yt_next = yt_reg - $signed(TERM_W'({rx2_reg, 1'b0}));
                end
                default: ;
            endcase

            unique case (ctrl.w.acc)
                ACC_HOLD:         ;
                ACC_INIT:         acc_next = (ry2_w <<< 2) - prod4;
                ACC_PLUS_RX2:     acc_next = acc_reg + rx2_w;
                ACC_DEC_PLUS_RY2: acc_next = dec_w + ry2_w;
                ACC_DEC_PLUS_RX2: acc_next = dec_w + rx2_w;
                ACC_PLUS_XT:      acc_next = acc_reg + xt_w;
                ACC_MINUS_YT:     acc_next = acc_reg - yt_w;
                ACC_FROM_PROD:    acc_next = prod_reg;
                ACC_PLUS_4PROD:   acc_next = acc_reg + prod4;
                ACC_MINUS_4PROD:  acc_next = acc_reg - prod4;
                default:          ;
            endcase

            unique case (ctrl.w.rop)
                ROP_NONE:      ;
                ROP_RX2_PROD:  rx2_next = prod_reg[SQ_W-1:0];
                ROP_RY2_PROD:  ry2_next = prod_reg[SQ_W-1:0];
                ROP_YT_2PROD:  yt_next  = $signed({prod_reg[TERM_W-2:0], 1'b0});
                ROP_TMP_PROD:  tmp_next = prod_reg[TMP_W-1:0];
                ROP_DEC_TRUNC: dec_next = $signed(dec_trunc);
                ROP_DEC_ACC:   dec_next = acc_reg[DEC_W-1:0];
                ROP_R2_ENTER: begin
                    dec_next  = $signed(dec_trunc);
                    r2_next   = 1'b1;
                    busy_next = (sy_reg != '0);
                end
                ROP_BUSY_UPD: begin
                    dec_next  = acc_reg[DEC_W-1:0];
                    busy_next = (sy_reg != '0);
                end
                default: ;
            endcase
        end
    end

    // Hold control state under reset; payload needs none
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            r2_reg   <= 1'b0;
            busy_reg <= 1'b0;
        end else begin
            r2_reg   <= r2_next;
            busy_reg <= busy_next;
        end
    end

    always_ff @(posedge aclk) begin
        cx_reg   <= cx_next;
        cy_reg   <= cy_next;
        rx_reg   <= rx_next;
        ry_reg   <= ry_next;
        rx2_reg  <= rx2_next;
        ry2_reg  <= ry2_next;
        sx_reg   <= sx_next;
        sy_reg   <= sy_next;
        dec_reg  <= dec_next;
        xt_reg   <= xt_next;
        yt_reg   <= yt_next;
        tmp_reg  <= tmp_next;
        prod_reg <= prod_next;
        acc_reg  <= acc_next;
    end

    // Report decision flags to the sequencer
    assign status.busy     = busy_reg;
    assign status.r2       = r2_reg;
    assign status.dec_neg  = dec_reg[DEC_W-1];
    assign status.dec_pos  = !dec_reg[DEC_W-1] && (dec_reg != '0);
    assign status.xt_lt_yt = (xt_reg < yt_reg);

    // Form the four symmetric points; last follows the busy flag this word leaves
    assign last_busy = ((ctrl.w.rop == ROP_R2_ENTER) || (ctrl.w.rop == ROP_BUSY_UPD))
                       ? (sy_reg != '0) : busy_reg;

    assign cx14 = OUT_W'(cx_reg);
    assign cy14 = OUT_W'(cy_reg);
    assign sx14 = OUT_W'(sx_reg);
    assign sy14 = OUT_W'(sy_reg);

    assign result.right_bottom_x = cx14 + sx14;
    assign result.right_bottom_y = cy14 + sy14;
    assign result.left_bottom_x  = cx14 - sx14;
    assign result.left_bottom_y  = cy14 + sy14;
    assign result.right_top_x    = cx14 + sx14;
    assign result.right_top_y    = cy14 - sy14;
    assign result.left_top_x     = cx14 - sx14;
    assign result.left_top_y     = cy14 - sy14;
    assign result.last           = !last_busy;

endmodule

/* rtl/core/midpoint_ellipse_rasterizer.sv */
// Top level of the midpoint ellipse rasterizer: stream ports and result register.
//
// The slave channel carries commands. s_tuser is the operation: a start
// transaction loads the center and the radii from s_tdata and sets up the
// region-one decision; a step transaction runs one iteration and yields
// one result with the four symmetric points. A step with no ellipse active
// is taken and gives nothing. The master channel carries the points; m_tlast
// marks the final iteration of the ellipse.
// Each transaction is run by a microprogram over one shared multiplier and
// one accumulator, one control word per cycle while no finishing word holds.
// A start sets up the region-one decision and, when region two begins at
// once, runs on through the region-two entry; a region-one step also runs
// through that entry when it passes into region two. s_tready is low while
// the microprogram runs. The result is registered and shows on the master
// side in the cycle after the last word. If the receiver stalls, the block
// keeps accepting work until a step is about to finish with the result
// register still full; that word then holds. Reset (aresetn low, synchronous)
// clears the sequencer, the valid flag of the result register and the busy flag, so no ellipse is active afterwards.
module midpoint_ellipse_rasterizer
    import mer_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // center_x[11:0], center_y[23:12], radius_x[33:24], radius_y[43:34], zero pad
    input  logic [47:0]  s_tdata,
    // operation[0]
    input  logic [0:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // right_bottom_x[13:0], right_bottom_y[27:14], left_bottom_x[41:28],
    // left_bottom_y[55:42], right_top_x[69:56], right_top_y[83:70],
    // left_top_x[97:84], left_top_y[111:98]
    output logic [111:0] m_tdata,
    output logic         m_tlast
);

    logic    in_fire;
    op_t     in_op;
    logic    running;
    logic    launch;
    logic    emit;
    logic    out_block;
    ctrl_t   ctrl;
    status_t status;
    result_t result;

    logic         m_tvalid_reg, m_tvalid_next;
    logic [111:0] m_tdata_reg, m_tdata_next;
    logic         m_tlast_reg, m_tlast_next;

    assign s_tready  = !running;
    assign in_fire   = s_tvalid && s_tready;
    assign in_op     = op_t'(s_tuser);
    assign out_block = m_tvalid_reg && !m_tready;

    mer_sequencer u_seq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_fire   (in_fire),
        .in_op     (in_op),
        .status    (status),
        .out_block (out_block),
        .running   (running),
        .launch    (launch),
        .ctrl      (ctrl),
        .emit      (emit)
    );

    mer_datapath u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .launch      (launch),
        .in_center_x (s_tdata[11:0]),
        .in_center_y (s_tdata[23:12]),
        .in_radius_x (s_tdata[33:24]),
        .in_radius_y (s_tdata[43:34]),
        .ctrl        (ctrl),
        .status      (status),
        .result      (result)
    );

    // Load the result register on emit, drop valid once the transaction is taken
    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        m_tlast_next  = m_tlast_reg;
        priority if (emit) begin
            m_tvalid_next = 1'b1;
            m_tdata_next  = {result.left_top_y, result.left_top_x,
                             result.right_top_y, result.right_top_x,
                             result.left_bottom_y, result.left_bottom_x,
                             result.right_bottom_y, result.right_bottom_x};
            m_tlast_next  = result.last;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_tdata_reg <= m_tdata_next;
        m_tlast_reg <= m_tlast_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

`ifndef SYNTHESIS
    // A result is never written over one that is still waiting
    a_emit_free: assert property (@(posedge aclk) disable iff (!aresetn)
        emit |-> !(m_tvalid && !m_tready))
        else $error("result emitted into a full output register");

    // An emitted result appears on the master side in the next cycle
    a_emit_shows: assert property (@(posedge aclk) disable iff (!aresetn)
        emit |=> m_tvalid)
        else $error("emitted result did not reach the output");

    // The microprogram stops only through an executed finishing word
    a_run_ends: assert property (@(posedge aclk) disable iff (!aresetn)
        $fell(running) |-> $past(ctrl.exec))
        else $error("sequencer stopped without executing a word");
`endif

endmodule

/* verif/mer_result_checker.sv */
// Point-set checker for the midpoint ellipse rasterizer: tracks the ellipse state and compares results.
module mer_result_checker
    import mer_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    input  logic         s_tready,
    input  logic [47:0]  s_tdata,
    input  logic [0:0]   s_tuser,
    input  logic         m_tvalid,
    input  logic         m_tready,
    input  logic [111:0] m_tdata,
    input  logic         m_tlast,
    output logic         ellipse_active,
    output int           pending_results,
    output int           mismatch_count
);

    // Tracked ellipse state
    longint centre_x   = 0;
    longint centre_y   = 0;
    longint cur_x      = 0;
    longint cur_y      = 0;
    longint decision   = 0;
    longint x_term     = 0;
    longint y_term     = 0;
    longint rx_sq      = 0;
    longint ry_sq      = 0;
    bit     region_two = 1'b0;
    bit     active     = 1'b0;
    int     fail_tally = 0;

    result_t predicted_points [$];

    // Switch to region two: quarter-unit initial decision, truncated toward zero
    function automatic void enter_region_two();
        longint tx;
        longint ym;
        longint quarter;
        tx = 2 * cur_x + 1;
        ym = cur_y - 1;
        quarter = ry_sq * tx * tx + 4 * rx_sq * ym * ym - 4 * rx_sq * ry_sq;
        decision = quarter / 4;
        region_two = 1'b1;
        active = (cur_y > 0);
    endfunction

    function automatic int field_mismatch(input string field,
                                          input logic [OUT_W-1:0] want,
                                          input logic [OUT_W-1:0] got);
        if (want !== got) begin
            $error("%s: expected %0d, actual %0d", field, $signed(want), $signed(got));
            return 1;
        end
        return 0;
    endfunction

    always @(posedge aclk) begin : track
        result_t want;
        result_t got;
        longint  rx;
        longint  ry;
        if (!aresetn) begin
            centre_x = 0;
            centre_y = 0;
            cur_x = 0;
            cur_y = 0;
            decision = 0;
            x_term = 0;
            y_term = 0;
            rx_sq = 0;
            ry_sq = 0;
            region_two = 1'b0;
            active = 1'b0;
            predicted_points.delete();
        end else begin
            // Compare a delivered point set with the oldest prediction
            if (m_tvalid && m_tready) begin
                got = {m_tdata, m_tlast};
                if (predicted_points.size() == 0) begin
                    $error("point set delivered with none predicted");
                    fail_tally++;
                end else begin
                    want = predicted_points.pop_front();
                    fail_tally += field_mismatch("right_bottom_x", want.right_bottom_x,
                                                 got.right_bottom_x);
                    fail_tally += field_mismatch("right_bottom_y", want.right_bottom_y,
                                                 got.right_bottom_y);
                    fail_tally += field_mismatch("left_bottom_x", want.left_bottom_x,
                                                 got.left_bottom_x);
                    fail_tally += field_mismatch("left_bottom_y", want.left_bottom_y,
                                                 got.left_bottom_y);
                    fail_tally += field_mismatch("right_top_x", want.right_top_x,
                                                 got.right_top_x);
                    fail_tally += field_mismatch("right_top_y", want.right_top_y,
                                                 got.right_top_y);
                    fail_tally += field_mismatch("left_top_x", want.left_top_x,
                                                 got.left_top_x);
                    fail_tally += field_mismatch("left_top_y", want.left_top_y,
                                                 got.left_top_y);
                    fail_tally += field_mismatch("last", OUT_W'(want.last), OUT_W'(got.last));
                end
            end

            // Advance the tracked ellipse on each accepted command
            if (s_tvalid && s_tready) begin
                if (op_t'(s_tuser) == OP_START) begin
                    rx = s_tdata[33:24];
                    ry = s_tdata[43:34];
                    centre_x = s_tdata[11:0];
                    centre_y = s_tdata[23:12];
                    rx_sq = rx * rx;
                    ry_sq = ry * ry;
                    cur_x = 0;
                    cur_y = ry;
                    x_term = 0;
                    y_term = 2 * rx_sq * ry;
                    decision = (4 * (ry_sq - rx_sq * ry) + rx_sq) / 4;
                    region_two = 1'b0;
                    active = 1'b1;
                    if (x_term >= y_term)
                        enter_region_two();
                end else if (active) begin
                    if (!region_two) begin
                        cur_x++;
                        x_term += 2 * ry_sq;
                        if (decision < 0) begin
                            decision += ry_sq + x_term;
                        end else begin
                            cur_y--;
                            y_term -= 2 * rx_sq;
                            decision += ry_sq + x_term - y_term;
                        end
                        if (x_term >= y_term)
                            enter_region_two();
                    end else begin
                        cur_y--;
                        y_term -= 2 * rx_sq;
                        if (decision > 0) begin
                            decision += rx_sq - y_term;
                        end else begin
                            cur_x++;
                            x_term += 2 * ry_sq;
                            decision += rx_sq - y_term + x_term;
                        end
                        active = (cur_y > 0);
                    end
                    want.right_bottom_x = OUT_W'(centre_x + cur_x);
                    want.right_bottom_y = OUT_W'(centre_y + cur_y);
                    want.left_bottom_x  = OUT_W'(centre_x - cur_x);
                    want.left_bottom_y  = OUT_W'(centre_y + cur_y);
                    want.right_top_x    = OUT_W'(centre_x + cur_x);
                    want.right_top_y    = OUT_W'(centre_y - cur_y);
                    want.left_top_x     = OUT_W'(centre_x - cur_x);
                    want.left_top_y     = OUT_W'(centre_y - cur_y);
                    want.last           = !active;
                    predicted_points.push_back(want);
                end
            end
        end
        ellipse_active  <= active;
        pending_results <= predicted_points.size();
        mismatch_count  <= fail_tally;
    end

endmodule

/* verif/tb_midpoint_ellipse_rasterizer.sv */
// Testbench top for the midpoint ellipse rasterizer: stimulus, flow control and verdict.
module tb_midpoint_ellipse_rasterizer;
    import mer_pkg::*;

    localparam int ITEM_TARGET     = 1250;
    localparam int RESET_CYCLES    = 8;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int WATCHDOG_LIMIT  = 2000;
    localparam int DRAIN_CYCLES    = 32;
    localparam int FULL_RUN        = 4096;

    logic         aclk     = 1'b0;
    logic         aresetn  = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [47:0]  s_tdata  = '0;
    logic [0:0]   s_tuser  = 1'b0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [111:0] m_tdata;
    logic         m_tlast;

    logic ellipse_active;
    int   pending_results;
    int   mismatch_count;

    int   sender_idle_pct = 34;
    int   recv_idle_pct   = 53;
    logic hold_off_req    = 1'b0;
    int   items_sent      = 0;
    int   quiet_cycles    = 0;

    midpoint_ellipse_rasterizer DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    mer_result_checker checker_i (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .s_tuser         (s_tuser),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .m_tlast         (m_tlast),
        .ellipse_active  (ellipse_active),
        .pending_results (pending_results),
        .mismatch_count  (mismatch_count)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // Offer one command, idling at random first, and wait for its transaction
    task automatic send_item(input op_t op, input logic [43:0] fields);
        while ($urandom_range(99) < sender_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {4'b0, fields};
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        items_sent++;
    endtask

    function automatic logic [43:0] noise_fields();
        return 44'({$urandom, $urandom});
    endfunction

    // Start an ellipse, then step it until it ends or the cap is reached.
    // The active flag lags by one transaction, so one idle step follows each end.
    task automatic run_ellipse(input int cx, input int cy, input int rx, input int ry,
                               input int step_cap);
        int taken;
        send_item(OP_START, {RADIUS_W'(ry), RADIUS_W'(rx), COORD_W'(cy), COORD_W'(cx)});
        taken = 0;
        while (taken < step_cap && (taken == 0 || ellipse_active)) begin
            send_item(OP_STEP, noise_fields());
            taken++;
        end
    endtask

    function automatic int pick_coord();
        int roll;
        roll = $urandom_range(9);
        if (roll == 0)
            return 0;
        if (roll == 1)
            return 4095;
        return $urandom_range(4095);
    endfunction

    // Receiver: random stalls, plus one long hold-off on request
    initial begin : receiver
        int hold_left;
        bit hold_off_done;
        hold_left = 0;
        hold_off_done = 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else if (hold_off_req && !hold_off_done) begin
                hold_left = HOLD_OFF_CYCLES;
                hold_off_done = 1'b1;
                m_tready <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // Abort when nothing moves on either channel for too long
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == WATCHDOG_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin : stimulus
        int  roll;
        bit  swapped;
        bit  calm;
        swapped = 1'b0;
        calm = 1'b0;
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: idle step, degenerate shapes, extremes, restart while active
        send_item(OP_STEP, '0);
        run_ellipse(0, 0, 0, 0, 2);
        run_ellipse(2048, 1024, 1023, 0, 2);
        run_ellipse(100, 200, 0, 3, 8);
        run_ellipse(4095, 4095, 1023, 1023, 2);
        run_ellipse(0, 0, 1023, 1, 2);
        run_ellipse(37, 4000, 1, 1023, 2);
        run_ellipse(1234, 2345, 3, 2, FULL_RUN);

        // Random ellipses: mostly small and complete, a few large and cut short
        while (items_sent < ITEM_TARGET) begin
            if (items_sent >= ITEM_TARGET / 3 && !swapped) begin
                sender_idle_pct <= 53;
                recv_idle_pct   <= 34;
                swapped = 1'b1;
            end
            if (items_sent >= 2 * ITEM_TARGET / 3 && !calm) begin
                sender_idle_pct <= 0;
                recv_idle_pct   <= 0;
                hold_off_req    <= 1'b1;
                calm = 1'b1;
            end
            roll = $urandom_range(99);
            if (roll < 75)
                run_ellipse(pick_coord(), pick_coord(), $urandom_range(12),
                            $urandom_range(12), FULL_RUN);
            else if (roll < 87)
                run_ellipse(pick_coord(), pick_coord(), $urandom_range(40),
                            $urandom_range(40), FULL_RUN);
            else
                run_ellipse(pick_coord(), pick_coord(), $urandom_range(1023),
                            $urandom_range(1023), $urandom_range(20));
            // stray steps between ellipses
            if ($urandom_range(9) == 0)
                repeat ($urandom_range(1, 3)) send_item(OP_STEP, noise_fields());
        end
        s_tvalid <= 1'b0;

        // Drain outstanding point sets, then let the block settle
        while (pending_results != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatch_count == 0 && pending_results == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
